@@ design/flp_pkg.sv @@
package flp_pkg;

    // Framing constants
    localparam logic [7:0] START_CODE = 8'hFF;
    localparam logic [7:0] PAD_BYTE   = 8'h00;

    // Parser phases
    localparam logic [2:0] PH_SEEK = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_LCS  = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_DCS  = 3'd4;
    localparam logic [2:0] PH_DONE = 3'd5;

    // Frame status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_LCS   = 3'd2;
    localparam logic [2:0] ST_DCS   = 3'd3;
    localparam logic [2:0] ST_TRUNC = 3'd4;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [2:0] status;
        logic [7:0] frame_length;
    } flp_result_t;

endpackage

@@ design/flp_core.sv @@
module flp_core
    import flp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  logic [7:0]  rx_byte,
    input  logic        window_end,
    output logic        result_valid,
    output flp_result_t result
);

    logic [2:0] phase_reg,  phase_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] left_reg,   left_next;
    logic [7:0] sum_reg,    sum_next;
    logic [7:0] left_dec;
    logic [7:0] len_check;
    logic [7:0] data_check;
    logic       have_payload;

    assign left_dec   = left_reg - 8'd1;
    assign len_check  = length_reg + rx_byte;
    assign data_check = sum_reg + rx_byte;

    // Advance the frame state by one item
    always_comb
    begin
        phase_next   = phase_reg;
        length_next  = length_reg;
        left_next    = left_reg;
        sum_next     = sum_reg;
        have_payload = 1'b0;
        result_valid = 1'b0;
        result       = '{kind: KIND_STATUS, payload_byte: 8'd0, status: ST_OK,
                         frame_length: length_reg};
        unique case (phase_reg)
            PH_SEEK:
            begin
                if (rx_byte == START_CODE)
                begin
                    phase_next = PH_LEN;
                end
                else if (rx_byte != PAD_BYTE || window_end)
                begin
                    result.status = ST_START;
                    result_valid  = 1'b1;
                    phase_next    = PH_DONE;
                end
            end
            PH_LEN:
            begin
                length_next = rx_byte;
                phase_next  = PH_LCS;
            end
            PH_LCS:
            begin
                if (len_check != 8'd0)
                begin
                    result.status = ST_LCS;
                    result_valid  = 1'b1;
                    phase_next    = PH_DONE;
                end
                else
                begin
                    left_next  = length_reg;
                    sum_next   = 8'd0;
                    phase_next = (length_reg == 8'd0) ? PH_DCS : PH_DATA;
                end
            end
            PH_DATA:
            begin
                sum_next     = data_check;
                left_next    = left_dec;
                have_payload = 1'b1;
                if (left_dec == 8'd0)
                begin
                    phase_next = PH_DCS;
                end
            end
            PH_DCS:
            begin
                result.status = (data_check == 8'd0) ? ST_OK : ST_DCS;
                result_valid  = 1'b1;
                phase_next    = PH_DONE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        // Close the window: report truncation if the frame is unfinished, then clear the frame
        if (window_end)
        begin
            if (phase_next != PH_DONE)
            begin
                result       = '{kind: KIND_STATUS, payload_byte: 8'd0, status: ST_TRUNC,
                                 frame_length: length_next};
                result_valid = 1'b1;
            end
            phase_next  = PH_SEEK;
            length_next = 8'd0;
            left_next   = 8'd0;
            sum_next    = 8'd0;
        end
        else if (have_payload)
        begin
            result       = '{kind: KIND_PAYLOAD, payload_byte: rx_byte, status: ST_OK,
                             frame_length: 8'd0};
            result_valid = 1'b1;
        end
    end

    // Hold state unless an item is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SEEK;
            length_reg <= 8'd0;
            left_reg   <= 8'd0;
            sum_reg    <= 8'd0;
        end
        else if (step_en)
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            left_reg   <= left_next;
            sum_reg    <= sum_next;
        end
    end

endmodule

@@ design/length_checksum_frame_parser_unit.sv @@
// An accepted input item is held in the input register; its result, if it has one,
// is registered in the output register, from which the receiver takes it.
// Throughput: 1 item per cycle while the output is not held; each byte needs one phase update and one 8-bit add.
// Back-pressure on the output stalls the input register, which stalls the input side.
// Reset (rst_n, asynchronous, active low) empties both registers and returns the
// parser to seeking the start code with length, count and sum cleared.
module length_checksum_frame_parser_unit
    import flp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tlast,   // window_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [10:8] status,
                                        // [18:11] frame_length, [23:19] zero
    output logic        m_axis_tuser    // kind
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    flp_result_t out_reg;
    logic        out_free;
    logic        step_en;
    logic        res_valid;
    flp_result_t res;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step_en       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || step_en;

    flp_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (step_en),
        .rx_byte      (in_byte_reg),
        .window_end   (in_last_reg),
        .result_valid (res_valid),
        .result       (res)
    );

    // Input register: take a new item when empty or whenever the current one moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step_en)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // Result register: load a result, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_en && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {5'd0, out_reg.frame_length, out_reg.status, out_reg.payload_byte};

`ifndef NO_ASSERTIONS
    // A payload item carries no status and no length
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_PAYLOAD |-> m_axis_tdata[18:8] == 11'd0)
        else $error("payload item with nonzero status or length");

    // A status item carries a defined code and no payload byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_STATUS
        |-> m_axis_tdata[10:8] <= ST_TRUNC && m_axis_tdata[7:0] == 8'd0)
        else $error("status item malformed");

    // A waiting input item is kept until processed
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step_en |=> in_valid_reg && $stable(in_byte_reg)
        && $stable(in_last_reg))
        else $error("input register lost a waiting item");

    // A produced result always shows up on the output
    assert property (@(posedge clk) disable iff (!rst_n)
        step_en && res_valid |=> m_axis_tvalid)
        else $error("result dropped");
`endif

endmodule
